/* rtl/astar_pkg.sv */
`default_nettype none
package astar_pkg;
	localparam int NODES = 16;
	localparam int NODE_BITS = 4;
	localparam int COORD_BITS = 8;
	localparam int COST_BITS = 24;
	localparam int MAX_OUT = 16;
	localparam logic [COST_BITS-1:0] COST_MAX = '1;
	localparam int SQ_BITS = 2 * COORD_BITS + 2 + 16;
	localparam int ROOT_BITS = (SQ_BITS + 1) / 2;

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_COORD = 2'd1,
		REQ_EDGE  = 2'd2,
		REQ_SEARCH = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_NB,
		ST_DIST_G,
		ST_DIST_H,
		ST_FIND,
		ST_SORT,
		ST_TRACE,
		ST_EMIT,
		ST_NOPATH
	} state_t;

	typedef struct packed {
		logic [NODE_BITS-1:0] node;
		logic [COST_BITS-1:0] cost;
		logic no_path;
		logic last_item;
	} out_t;
endpackage
`default_nettype wire

/* rtl/astar_if.sv */
`default_nettype none
interface astar_req_if;
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic [3:0] node_a;
	logic [3:0] node_b;
	logic [7:0] coord_x;
	logic [7:0] coord_y;
	modport source(output valid, req_type, node_a, node_b, coord_x, coord_y, input ready);
	modport sink(input valid, req_type, node_a, node_b, coord_x, coord_y, output ready);
endinterface

interface astar_res_if;
	logic valid;
	logic ready;
	logic [3:0] path_node;
	logic [23:0] total_cost;
	logic no_path;
	logic last_item;
	modport source(output valid, path_node, total_cost, no_path, last_item, input ready);
	modport sink(input valid, path_node, total_cost, no_path, last_item, output ready);
endinterface
`default_nettype wire

/* rtl/a_star_shortest_path_core.sv */
// channel  | dir | fields
// req      | in  | req_type node_a node_b coord_x coord_y
// res      | out | path_node total_cost no_path last_item
// Clear, coordinate and edge items are taken in the idle state; a search runs on a
// sequencer with one shared distance unit, one list slot moved per cycle in the sort,
// and one trace step per result. Reset clears the graph at once.
// The result register holds while res.ready is low; no item is taken meanwhile.
`default_nettype none
module a_star_shortest_path_core
	import astar_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	astar_req_if.sink req,
	astar_res_if.source res
);
	logic [COORD_BITS-1:0] nx_q [NODES];
	logic [COORD_BITS-1:0] ny_q [NODES];
	logic [NODES-1:0] adj_q [NODES];
	logic [NODE_BITS-1:0] on_q [NODES];
	logic [COST_BITS-1:0] oc_q [NODES];
	logic [COST_BITS-1:0] oh_q [NODES];
	logic [NODE_BITS-1:0] ov_q [NODES];
	logic [NODES-1:0] vis_q;
	logic [NODE_BITS:0] cnt_q, set_q, idx_q, j_q;
	logic [NODE_BITS-1:0] start_q, goal_q, cur_q, nb_q, trn_q;
	logic [COST_BITS-1:0] curg_q, g_q, total_q;
	logic [4:0] k_q;
	logic dstart_q;
	state_t st_q, st_d;
	out_t out_q;
	logic out_v_q;
	logic out_load;

	logic dbusy;
	logic [COST_BITS-1:0] dist_val;
	logic [NODE_BITS-1:0] da, db;
	assign da = (st_q == ST_DIST_H) ? nb_q : cur_q;
	assign db = (st_q == ST_DIST_H) ? goal_q : nb_q;
	astar_dist u_dist (
		.clk(clk), .arst_n(arst_n), .start(dstart_q),
		.xa(nx_q[da]), .ya(ny_q[da]), .xb(nx_q[db]), .yb(ny_q[db]),
		.busy(dbusy), .dist_out(dist_val)
	);

	logic [COST_BITS:0] gsum;
	assign gsum = {1'b0, curg_q} + {1'b0, dist_val};
	logic [COST_BITS:0] key_p, key_j;
	logic [NODE_BITS-1:0] jl, jp;
	assign jl = j_q[NODE_BITS-1:0];
	assign jp = jl - 1'b1;
	assign key_p = {1'b0, oc_q[jp]} + {1'b0, oh_q[jp]};
	assign key_j = {1'b0, oc_q[jl]} + {1'b0, oh_q[jl]};
	logic [NODE_BITS-1:0] il;
	assign il = idx_q[NODE_BITS-1:0];
	logic [NODE_BITS-1:0] sl;
	assign sl = set_q[NODE_BITS-1:0];

	assign out_load = (st_q == ST_EMIT || st_q == ST_NOPATH) && (!out_v_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (req.valid && req.ready && req.req_type == REQ_SEARCH) st_d = ST_CHECK;
			ST_CHECK: begin
				if (set_q >= cnt_q) st_d = ST_NOPATH;
				else if (on_q[sl] == goal_q) st_d = ST_TRACE;
				else st_d = ST_NB;
			end
			ST_NB: begin
				if (nb_q == NODE_BITS'(NODES - 1) && !(adj_q[cur_q][nb_q] && !vis_q[nb_q]))
					st_d = ST_CHECK;
				else if (adj_q[cur_q][nb_q] && !vis_q[nb_q]) st_d = ST_DIST_G;
			end
			ST_DIST_G: if (!dstart_q && !dbusy) st_d = ST_DIST_H;
			ST_DIST_H: if (!dstart_q && !dbusy) st_d = ST_FIND;
			ST_FIND: if (idx_q >= cnt_q || on_q[il] == nb_q) st_d = ST_SORT;
			ST_SORT: if (idx_q >= cnt_q) begin
				st_d = (nb_q == NODE_BITS'(NODES - 1)) ? ST_CHECK : ST_NB;
			end
			ST_TRACE: if (!out_v_q || res.ready) begin
				if (idx_q >= cnt_q || on_q[il] == trn_q) st_d = ST_EMIT;
			end
			ST_EMIT: if (!out_v_q || res.ready) begin
				if (trn_q == start_q || idx_q >= cnt_q || k_q == 5'(MAX_OUT - 1))
					st_d = ST_IDLE;
				else st_d = ST_TRACE;
			end
			ST_NOPATH: if (!out_v_q || res.ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	assign req.ready = (st_q == ST_IDLE) && !out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				nx_q[i] <= '0;
				ny_q[i] <= '0;
				adj_q[i] <= '0;
			end
			vis_q <= '0;
			cnt_q <= '0;
			set_q <= '0;
			out_v_q <= 1'b0;
			dstart_q <= 1'b0;
		end else begin
			dstart_q <= (st_q == ST_NB && adj_q[cur_q][nb_q] && !vis_q[nb_q])
				|| (st_q == ST_DIST_G && !dstart_q && !dbusy);
			out_v_q <= out_load || (out_v_q && !res.ready);
			case (st_q)
				ST_IDLE: if (req.valid && req.ready) begin
					case (req_t'(req.req_type))
						REQ_CLEAR: begin
							for (int i = 0; i < NODES; i++) begin
								nx_q[i] <= '0;
								ny_q[i] <= '0;
								adj_q[i] <= '0;
							end
							vis_q <= '0;
							cnt_q <= '0;
							set_q <= '0;
						end
						REQ_COORD: begin
							nx_q[req.node_a] <= req.coord_x;
							ny_q[req.node_a] <= req.coord_y;
						end
						REQ_EDGE: if (req.node_a != req.node_b) begin
							adj_q[req.node_a][req.node_b] <= 1'b1;
							adj_q[req.node_b][req.node_a] <= 1'b1;
						end
						default: begin
							start_q <= req.node_a;
							goal_q <= req.node_b;
							vis_q <= '0;
							on_q[0] <= req.node_a;
							oc_q[0] <= '0;
							oh_q[0] <= '0;
							ov_q[0] <= req.node_a;
							cnt_q <= 5'd1;
							set_q <= '0;
							k_q <= '0;
						end
					endcase
				end
				ST_CHECK: begin
					if (set_q < cnt_q && on_q[sl] != goal_q) begin
						cur_q <= on_q[sl];
						curg_q <= oc_q[sl];
						vis_q[on_q[sl]] <= 1'b1;
						set_q <= set_q + 1'b1;
						nb_q <= '0;
					end else if (set_q < cnt_q) begin
						total_q <= oc_q[sl];
						trn_q <= goal_q;
						idx_q <= '0;
					end
				end
				ST_NB: if (!(adj_q[cur_q][nb_q] && !vis_q[nb_q])
						&& nb_q != NODE_BITS'(NODES - 1))
					nb_q <= nb_q + 1'b1;
				ST_DIST_G: if (!dstart_q && !dbusy)
					g_q <= gsum[COST_BITS] ? COST_MAX : gsum[COST_BITS-1:0];
				ST_DIST_H: if (!dstart_q && !dbusy) idx_q <= '0;
				ST_FIND: begin
					if (idx_q < cnt_q && on_q[il] == nb_q) begin
						if (idx_q >= set_q && g_q <= oc_q[il]) begin
							oc_q[il] <= g_q;
							oh_q[il] <= dist_val;
							ov_q[il] <= cur_q;
						end
						idx_q <= set_q + 1'b1;
						j_q <= set_q + 1'b1;
					end else if (idx_q >= cnt_q) begin
						if (cnt_q < 5'(NODES)) begin
							on_q[cnt_q[NODE_BITS-1:0]] <= nb_q;
							oc_q[cnt_q[NODE_BITS-1:0]] <= g_q;
							oh_q[cnt_q[NODE_BITS-1:0]] <= dist_val;
							ov_q[cnt_q[NODE_BITS-1:0]] <= cur_q;
							cnt_q <= cnt_q + 1'b1;
						end
						idx_q <= set_q + 1'b1;
						j_q <= set_q + 1'b1;
					end else idx_q <= idx_q + 1'b1;
				end
				ST_SORT: begin
					if (idx_q < cnt_q) begin
						if (j_q > set_q && key_p > key_j) begin
							on_q[jp] <= on_q[jl]; on_q[jl] <= on_q[jp];
							oc_q[jp] <= oc_q[jl]; oc_q[jl] <= oc_q[jp];
							oh_q[jp] <= oh_q[jl]; oh_q[jl] <= oh_q[jp];
							ov_q[jp] <= ov_q[jl]; ov_q[jl] <= ov_q[jp];
							j_q <= j_q - 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
							j_q <= idx_q + 1'b1;
						end
					end else if (nb_q != NODE_BITS'(NODES - 1)) nb_q <= nb_q + 1'b1;
				end
				ST_TRACE: if (!out_v_q || res.ready) begin
					if (!(idx_q >= cnt_q || on_q[il] == trn_q)) idx_q <= idx_q + 1'b1;
				end
				ST_EMIT: if (!out_v_q || res.ready) begin
					out_q.node <= trn_q;
					out_q.cost <= total_q;
					out_q.no_path <= 1'b0;
					out_q.last_item <= (trn_q == start_q || idx_q >= cnt_q
						|| k_q == 5'(MAX_OUT - 1));
					k_q <= k_q + 1'b1;
					trn_q <= ov_q[il];
					idx_q <= '0;
				end
				ST_NOPATH: if (!out_v_q || res.ready) begin
					out_q.node <= '0;
					out_q.cost <= '0;
					out_q.no_path <= 1'b1;
					out_q.last_item <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign res.valid = out_v_q;
	assign res.path_node = out_q.node;
	assign res.total_cost = out_q.cost;
	assign res.no_path = out_q.no_path;
	assign res.last_item = out_q.last_item;

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 5'(NODES))
		else $error("open count overflow");
	a_set: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_NB |-> set_q <= cnt_q) else $error("settled beyond list");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> st_q == ST_IDLE) else $error("ready while busy");
endmodule
`default_nettype wire

/* rtl/astar_dist.sv */
`default_nettype none
module astar_dist
	import astar_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [COORD_BITS-1:0] xa,
	input wire logic [COORD_BITS-1:0] ya,
	input wire logic [COORD_BITS-1:0] xb,
	input wire logic [COORD_BITS-1:0] yb,
	output logic busy,
	output logic [COST_BITS-1:0] dist_out
);
	// one root bit per cycle after the setup that squares the deltas and then sums them
	localparam int CNT_BITS = $clog2(ROOT_BITS + 3);
	logic [COORD_BITS-1:0] dx_q, dy_q;
	logic [2*COORD_BITS-1:0] rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [1:0] phase_q;
	logic [2*COORD_BITS-1:0] sq_q;

	logic [SQ_BITS-1:0] val_q;
	logic [SQ_BITS+1:0] part_q;
	logic [SQ_BITS+1:0] cand;
	logic [SQ_BITS+1:0] nrem;
	always_comb begin
		nrem = {part_q[SQ_BITS-1:0], val_q[SQ_BITS-1 -: 2]};
		cand = (SQ_BITS+2)'({root_q, 2'b01});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			cnt_q <= '0;
		end else if (start) begin
			phase_q <= 2'd1;
			cnt_q <= '0;
		end else if (phase_q == 2'd1) begin
			phase_q <= 2'd2;
		end else if (phase_q == 2'd2) begin
			phase_q <= 2'd3;
		end else if (phase_q == 2'd3) begin
			if (cnt_q == CNT_BITS'(ROOT_BITS - 1))
				phase_q <= 2'd0;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dx_q <= (xa > xb) ? xa - xb : xb - xa;
			dy_q <= (ya > yb) ? ya - yb : yb - ya;
		end else if (phase_q == 2'd1) begin
			sq_q <= dx_q * dx_q;
			rem_q <= dy_q * dy_q;
		end else if (phase_q == 2'd2) begin
			val_q <= (SQ_BITS'(sq_q) + SQ_BITS'(rem_q)) << 16;
			part_q <= '0;
			root_q <= '0;
		end else if (phase_q == 2'd3) begin
			val_q <= val_q << 2;
			if (nrem >= cand) begin
				part_q <= nrem - cand;
				root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
			end else begin
				part_q <= nrem;
				root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy = start || phase_q != 2'd0;
	assign dist_out = (ROOT_BITS > COST_BITS && |(root_q >> COST_BITS)) ? COST_MAX
		: COST_BITS'(root_q);
endmodule
`default_nettype wire

/* verif/tb_a_star_shortest_path_core.sv */
`default_nettype none
module tb_a_star_shortest_path_core
	import astar_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	astar_req_if req_ch();
	astar_res_if res_ch();

	a_star_shortest_path_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.res(res_ch.source)
	);

	logic [7:0] gx [NODES];
	logic [7:0] gy [NODES];
	logic [NODES-1:0] adj [NODES];
	logic [3:0] ol_node [NODES];
	logic [23:0] ol_cost [NODES];
	logic [23:0] ol_heur [NODES];
	logic [3:0] ol_via [NODES];
	logic [NODES-1:0] seen;
	int ol_count;
	int ol_settled;

	out_t path_q[$];
	int fail_cnt;
	int mismatch_cnt;
	bit idle_off;
	bit hold_req;
	int hold_cycles;
	int idle_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#80ms;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [23:0] euclid(int p, int q);
		logic [63:0] dx;
		logic [63:0] dy;
		logic [63:0] r;
		dx = gx[p] > gx[q] ? gx[p] - gx[q] : gx[q] - gx[p];
		dy = gy[p] > gy[q] ? gy[p] - gy[q] : gy[q] - gy[p];
		r = int_sqrt((dx * dx + dy * dy) << 16);
		return r > 64'(COST_MAX) ? COST_MAX : r[23:0];
	endfunction

	function automatic logic [23:0] add_sat(logic [23:0] a, logic [23:0] b);
		logic [24:0] s;
		s = a + b;
		return s > 25'(COST_MAX) ? COST_MAX : s[23:0];
	endfunction

	function automatic void sort_open();
		logic [3:0] n;
		logic [3:0] v;
		logic [23:0] c;
		logic [23:0] h;
		int j;
		for (int i = ol_settled + 1; i < ol_count; i++) begin
			n = ol_node[i]; c = ol_cost[i]; h = ol_heur[i]; v = ol_via[i];
			j = i;
			while (j > ol_settled &&
					({1'b0, ol_cost[j-1]} + ol_heur[j-1]) > ({1'b0, c} + h)) begin
				ol_node[j] = ol_node[j-1];
				ol_cost[j] = ol_cost[j-1];
				ol_heur[j] = ol_heur[j-1];
				ol_via[j] = ol_via[j-1];
				j--;
			end
			ol_node[j] = n; ol_cost[j] = c; ol_heur[j] = h; ol_via[j] = v;
		end
	endfunction

	function automatic int open_pos(logic [3:0] n);
		for (int i = 0; i < ol_count; i++)
			if (ol_node[i] == n) return i;
		return -1;
	endfunction

	function automatic void push_path(logic [3:0] n, logic [23:0] c, bit np, bit last);
		out_t o;
		o.node = n; o.cost = c; o.no_path = np; o.last_item = last;
		path_q.push_back(o);
	endfunction

	function automatic void clear_graph();
		for (int i = 0; i < NODES; i++) begin
			gx[i] = '0; gy[i] = '0; adj[i] = '0;
		end
		seen = '0; ol_count = 0; ol_settled = 0;
	endfunction

	function automatic void predict_search(logic [3:0] s, logic [3:0] goal);
		int cur;
		int idx;
		int p;
		logic [3:0] n;
		logic [23:0] g;
		logic [23:0] total;
		seen = '0;
		ol_node[0] = s; ol_cost[0] = '0; ol_heur[0] = '0; ol_via[0] = s;
		ol_count = 1; ol_settled = 0;
		forever begin
			if (ol_settled >= ol_count) begin
				push_path(4'd0, 24'd0, 1'b1, 1'b1);
				return;
			end
			cur = ol_settled;
			if (ol_node[cur] == goal) break;
			n = ol_node[cur];
			seen[n] = 1'b1;
			ol_settled++;
			for (int nb = 0; nb < NODES; nb++) begin
				if (adj[n][nb] && !seen[nb]) begin
					g = add_sat(ol_cost[cur], euclid(n, nb));
					p = open_pos(4'(nb));
					if (p >= 0) begin
						if (p >= ol_settled && g <= ol_cost[p]) begin
							ol_cost[p] = g; ol_heur[p] = euclid(nb, goal); ol_via[p] = n;
						end
					end else if (ol_count < NODES) begin
						ol_node[ol_count] = 4'(nb); ol_cost[ol_count] = g;
						ol_heur[ol_count] = euclid(nb, goal); ol_via[ol_count] = n;
						ol_count++;
					end
					sort_open();
				end
			end
		end
		total = ol_cost[ol_settled];
		n = goal;
		for (int k = 0; k < MAX_OUT; k++) begin
			idx = open_pos(n);
			if (n == s || idx < 0 || k == MAX_OUT - 1) begin
				push_path(n, total, 1'b0, 1'b1);
				return;
			end
			push_path(n, total, 1'b0, 1'b0);
			n = ol_via[idx];
		end
	endfunction

	function automatic void predict(req_t t, logic [3:0] a, logic [3:0] b,
			logic [7:0] x, logic [7:0] y);
		case (t)
			REQ_CLEAR: clear_graph();
			REQ_COORD: begin
				gx[a] = x; gy[a] = y;
			end
			REQ_EDGE: begin
				if (a != b) begin
					adj[a][b] = 1'b1; adj[b][a] = 1'b1;
				end
			end
			default: predict_search(a, b);
		endcase
	endfunction

	task automatic gap();
		if (!idle_off && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
	endtask

	task automatic send_item(req_t t, int a, int b, int x, int y);
		gap();
		req_ch.valid <= 1'b1;
		req_ch.req_type <= t;
		req_ch.node_a <= 4'(a);
		req_ch.node_b <= 4'(b);
		req_ch.coord_x <= 8'(x);
		req_ch.coord_y <= 8'(y);
		do @(posedge clk); while (!req_ch.ready);
		predict(t, 4'(a), 4'(b), 8'(x), 8'(y));
		@(negedge clk);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (path_q.size() != 0) @(negedge clk);
		repeat (2000) @(negedge clk);
	endtask

	task automatic set_node(int n, int x, int y);
		send_item(REQ_COORD, n, int'($urandom), x, y);
	endtask

	task automatic test_directed();
		send_item(REQ_CLEAR, 4'hf, 4'h0, 8'hff, 8'h00);
		send_item(REQ_SEARCH, 4'd3, 4'd3, 0, 0);
		send_item(REQ_SEARCH, 4'd0, 4'd15, 0, 0);
		set_node(0, 0, 0);
		set_node(1, 255, 255);
		set_node(2, 255, 0);
		set_node(15, 0, 255);
		send_item(REQ_EDGE, 4'd0, 4'd0, 0, 0);
		send_item(REQ_EDGE, 4'd0, 4'd2, 0, 0);
		send_item(REQ_EDGE, 4'd2, 4'd1, 0, 0);
		send_item(REQ_EDGE, 4'd0, 4'd15, 0, 0);
		send_item(REQ_EDGE, 4'd15, 4'd1, 0, 0);
		send_item(REQ_SEARCH, 4'd0, 4'd1, 0, 0);
		send_item(REQ_SEARCH, 4'd1, 4'd0, 0, 0);
		send_item(REQ_SEARCH, 4'd0, 4'd5, 0, 0);
		for (int i = 0; i < 15; i++) send_item(REQ_EDGE, i, i + 1, 0, 0);
		send_item(REQ_SEARCH, 4'd15, 4'd0, 0, 0);
		send_item(REQ_CLEAR, 0, 0, 0, 0);
		send_item(REQ_SEARCH, 4'd0, 4'd1, 0, 0);
		drain();
	endtask

	task automatic build_graph(int edges);
		send_item(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom);
		for (int i = 0; i < NODES; i++)
			if ($urandom_range(0, 4) != 0) set_node(i, $urandom, $urandom);
		for (int i = 0; i < edges; i++)
			send_item(REQ_EDGE, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic test_random(int n_items);
		int sent;
		sent = 0;
		while (sent < n_items) begin
			build_graph($urandom_range(4, 24));
			sent += 30;
			repeat ($urandom_range(2, 6)) begin
				send_item(REQ_SEARCH, $urandom, $urandom, $urandom, $urandom);
				sent++;
			end
		end
	endtask

	task automatic test_chain_stall();
		send_item(REQ_CLEAR, 0, 0, 0, 0);
		for (int i = 0; i < NODES; i++) set_node(i, i * 17, 255 - i * 3);
		for (int i = 0; i < 15; i++) send_item(REQ_EDGE, i + 1, i, 0, 0);
		hold_cycles = 3000;
		hold_req = 1'b1;
		repeat (4) send_item(REQ_SEARCH, 4'd0, 4'd15, 0, 0);
		drain();
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			res_ch.ready <= 1'b0;
			hold_cycles--;
			if (hold_cycles <= 0) hold_req <= 1'b0;
		end else if (idle_left > 0) begin
			res_ch.ready <= 1'b0;
			idle_left--;
		end else if (!idle_off && $urandom_range(0, 15) == 0) begin
			res_ch.ready <= 1'b0;
			idle_left = $urandom_range(0, 14);
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (path_q.size() == 0) begin
				fail_cnt++;
				$display("unexpected result node=%0d", res_ch.path_node);
			end else begin
				want = path_q.pop_front();
				if (res_ch.path_node !== want.node || res_ch.total_cost !== want.cost ||
						res_ch.no_path !== want.no_path ||
						res_ch.last_item !== want.last_item) begin
					fail_cnt++;
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch exp %0d %h %b %b got %0d %h %b %b",
							want.node, want.cost, want.no_path, want.last_item,
							res_ch.path_node, res_ch.total_cost, res_ch.no_path,
							res_ch.last_item);
				end
			end
		end
	end

	initial begin
		fail_cnt = 0;
		mismatch_cnt = 0;
		idle_off = 1'b0;
		hold_req = 1'b0;
		hold_cycles = 0;
		idle_left = 0;
		clear_graph();
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_CLEAR;
		req_ch.node_a = '0;
		req_ch.node_b = '0;
		req_ch.coord_x = '0;
		req_ch.coord_y = '0;
		res_ch.ready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_chain_stall();
		test_random(180);
		idle_off = 1'b1;
		test_random(60);
		drain();
		if (fail_cnt == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
rtl/astar_pkg.sv
rtl/astar_if.sv
rtl/astar_dist.sv
rtl/a_star_shortest_path_core.sv
verif/tb_a_star_shortest_path_core.sv
